[sv/pip_pkg.sv]
`timescale 1ns / 1ps

package pip_pkg;

  localparam int COORD_WIDTH_DEF  = 32;
  localparam int MAX_VERTICES_DEF = 4;

  // Stream field layout
  localparam int FIELD_W      = 32;
  localparam int NUM_VERT     = 4;
  localparam int VCOUNT_W     = 3;
  localparam int COUNT_W      = 3;
  localparam int PX_LSB       = 0;
  localparam int PY_LSB       = FIELD_W;
  localparam int VERT_LSB     = 2 * FIELD_W;
  localparam int VCOUNT_LSB   = (2 + 2 * NUM_VERT) * FIELD_W;
  localparam int IN_FIELDS_W  = VCOUNT_LSB + VCOUNT_W;
  localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = 1 + COUNT_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  // Pipeline: input reg, edge diff, edge select, partial products, product sum, output reg
  localparam int NUM_STAGES = 6;

  // Load enables for the two register stages inside a datapath unit
  typedef struct packed {
    logic ld_a;
    logic ld_b;
  } pip_ld_t;

endpackage

[sv/pip_edge.sv]
`timescale 1ns / 1ps

module pip_edge #(
  parameter int COORD_WIDTH = pip_pkg::COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  pip_pkg::pip_ld_t              ld,
  input  logic                          edge_used,
  input  logic signed [COORD_WIDTH-1:0] px,
  input  logic signed [COORD_WIDTH-1:0] py,
  input  logic signed [COORD_WIDTH-1:0] xi,
  input  logic signed [COORD_WIDTH-1:0] yi,
  input  logic signed [COORD_WIDTH-1:0] xj,
  input  logic signed [COORD_WIDTH-1:0] yj,
  output logic signed [COORD_WIDTH:0]   dyp,
  output logic signed [COORD_WIDTH:0]   dxe,
  output logic signed [COORD_WIDTH:0]   dxp,
  output logic signed [COORD_WIDTH:0]   dye,
  output logic                          hit_en
);

  localparam int DW = COORD_WIDTH + 1;

  logic signed [DW-1:0] px_x, py_x, xi_x, yi_x, xj_x, yj_x;

  // Stage A: every difference and compare for both edge orientations
  logic signed [DW-1:0] dyi_r, dyj_r, dxij_r, dxji_r, dyij_r, dyji_r, dxpi_r, dxpj_r;
  logic                 lt_r, eq_r, pgi_r, pgj_r, pli_r, plj_r, used_r;

  // Stage B: operands oriented from the lower end of the edge
  logic signed [DW-1:0] dyp_r, dxe_r, dxp_r, dye_r;
  logic                 en_r;

  assign px_x = $signed({px[COORD_WIDTH-1], px});
  assign py_x = $signed({py[COORD_WIDTH-1], py});
  assign xi_x = $signed({xi[COORD_WIDTH-1], xi});
  assign yi_x = $signed({yi[COORD_WIDTH-1], yi});
  assign xj_x = $signed({xj[COORD_WIDTH-1], xj});
  assign yj_x = $signed({yj[COORD_WIDTH-1], yj});

  always_ff @(posedge clk) begin
    if (ld.ld_a) begin
      dyi_r  <= py_x - yi_x;
      dyj_r  <= py_x - yj_x;
      dxij_r <= xj_x - xi_x;
      dxji_r <= xi_x - xj_x;
      dyij_r <= yj_x - yi_x;
      dyji_r <= yi_x - yj_x;
      dxpi_r <= px_x - xi_x;
      dxpj_r <= px_x - xj_x;
      lt_r   <= yi < yj;
      eq_r   <= yi == yj;
      pgi_r  <= py > yi;
      pgj_r  <= py > yj;
      pli_r  <= py <= yi;
      plj_r  <= py <= yj;
      used_r <= edge_used;
    end
  end

  always_ff @(posedge clk) begin
    if (ld.ld_b) begin
      if (lt_r) begin
        dyp_r <= dyi_r;
        dxe_r <= dxij_r;
        dxp_r <= dxpi_r;
        dye_r <= dyij_r;
        en_r  <= used_r && !eq_r && pgi_r && plj_r;
      end else begin
        dyp_r <= dyj_r;
        dxe_r <= dxji_r;
        dxp_r <= dxpj_r;
        dye_r <= dyji_r;
        // horizontal edges drop out through eq_r
        en_r  <= used_r && !eq_r && pgj_r && pli_r;
      end
    end
  end

  assign dyp    = dyp_r;
  assign dxe    = dxe_r;
  assign dxp    = dxp_r;
  assign dye    = dye_r;
  assign hit_en = en_r;

endmodule

[sv/pip_mul.sv]
`timescale 1ns / 1ps

module pip_mul #(
  parameter int AW = pip_pkg::COORD_WIDTH_DEF + 1
) (
  input  logic                   clk,
  input  pip_pkg::pip_ld_t       ld,
  input  logic signed [AW-1:0]   a,
  input  logic signed [AW-1:0]   b,
  output logic signed [2*AW-1:0] prod
);

  // Split b into an unsigned low half and a signed high half
  localparam int LW  = (AW + 1) / 2;
  localparam int HW  = AW - LW;
  localparam int PLW = AW + LW + 1;
  localparam int PHW = AW + HW;

  logic signed [PLW-1:0]  a_l, b_l, pl_nxt, pl_r;
  logic signed [PHW-1:0]  a_h, b_h, ph_nxt, ph_r;
  logic signed [2*AW-1:0] prod_nxt, prod_r;

  always_comb begin
    a_l    = $signed({{(LW + 1){a[AW-1]}}, a});
    b_l    = $signed({{(AW + 1){1'b0}}, b[LW-1:0]});
    a_h    = $signed({{HW{a[AW-1]}}, a});
    b_h    = $signed({{AW{b[AW-1]}}, b[AW-1:LW]});
    pl_nxt = a_l * b_l;
    ph_nxt = a_h * b_h;
  end

  assign prod_nxt = $signed({ph_r, {LW{1'b0}}}) + $signed({{(2 * AW - PLW){pl_r[PLW-1]}}, pl_r});

  always_ff @(posedge clk) begin
    if (ld.ld_a) begin
      pl_r <= pl_nxt;
      ph_r <= ph_nxt;
    end
    if (ld.ld_b) begin
      prod_r <= prod_nxt;
    end
  end

  assign prod = prod_r;

endmodule

[sv/point_in_polygon_test.sv]
`timescale 1ns / 1ps
// Channel  Dir  Handshake              Payload
// in_      in   in_tvalid/in_tready    point, four vertices, vertex_count (in_tdata)
// out_     out  out_tvalid/out_tready  inside_res, crossing_count (out_tdata)
//
// One item per cycle sustained while out_tready holds; there are six register
// stages: input, edge differences, edge orientation, partial products, product
// sum, and the compare/count output register.
// rst_n clears only the stage valid bits. A stalled output holds its item while
// earlier stages keep advancing into any empty stage behind it.

module point_in_polygon_test #(
  parameter int COORD_WIDTH  = pip_pkg::COORD_WIDTH_DEF,
  parameter int MAX_VERTICES = pip_pkg::MAX_VERTICES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // point_x, point_y, vertex0_x, vertex0_y, vertex1_x, vertex1_y,
  // vertex2_x, vertex2_y, vertex3_x, vertex3_y, vertex_count, zero pad
  input  logic [pip_pkg::IN_TDATA_W-1:0]  in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // inside_res, crossing_count, zero pad
  output logic [pip_pkg::OUT_TDATA_W-1:0] out_tdata
);

  localparam int DW = COORD_WIDTH + 1;
  localparam int PW = 2 * DW;
  localparam int NS = pip_pkg::NUM_STAGES;
  localparam int NV = pip_pkg::NUM_VERT;
  localparam int FW = pip_pkg::FIELD_W;
  localparam int CW = pip_pkg::COUNT_W;

  logic [NS:1] vld_r, vld_nxt, adv;

  // Stage 1 payload
  logic signed [COORD_WIDTH-1:0] px_r, py_r;
  logic signed [COORD_WIDTH-1:0] vx_r [NV];
  logic signed [COORD_WIDTH-1:0] vy_r [NV];
  logic                          quad_r;

  // Per-edge lanes
  logic signed [COORD_WIDTH-1:0] xj   [MAX_VERTICES];
  logic signed [COORD_WIDTH-1:0] yj   [MAX_VERTICES];
  logic                          used [MAX_VERTICES];
  logic signed [DW-1:0]          dyp [MAX_VERTICES];
  logic signed [DW-1:0]          dxe [MAX_VERTICES];
  logic signed [DW-1:0]          dxp [MAX_VERTICES];
  logic signed [DW-1:0]          dye [MAX_VERTICES];
  logic                          en3 [MAX_VERTICES];
  logic [MAX_VERTICES-1:0]       en4_r, en5_r;
  logic signed [PW-1:0]          lhs [MAX_VERTICES];
  logic signed [PW-1:0]          rhs [MAX_VERTICES];

  pip_pkg::pip_ld_t ld_edge, ld_mul;

  logic [CW-1:0] count_nxt, count_r;

  // Stage handshake: a stage loads when it is empty or its successor loads
  always_comb begin
    adv[NS] = !vld_r[NS] || out_tready;
    for (int k = NS - 1; k >= 1; k--) begin
      adv[k] = !vld_r[k] || adv[k+1];
    end
    vld_nxt[1] = adv[1] ? in_tvalid : vld_r[1];
    for (int k = 2; k <= NS; k++) begin
      vld_nxt[k] = adv[k] ? vld_r[k-1] : vld_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_tready  = adv[1];
  assign out_tvalid = vld_r[NS];

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      px_r <= COORD_WIDTH'(in_tdata[pip_pkg::PX_LSB +: FW]);
      py_r <= COORD_WIDTH'(in_tdata[pip_pkg::PY_LSB +: FW]);
      for (int v = 0; v < NV; v++) begin
        vx_r[v] <= COORD_WIDTH'(in_tdata[pip_pkg::VERT_LSB + 2 * v * FW +: FW]);
        vy_r[v] <= COORD_WIDTH'(in_tdata[pip_pkg::VERT_LSB + (2 * v + 1) * FW +: FW]);
      end
      // counts of four and up mean a quadrilateral
      quad_r <= (MAX_VERTICES == NV) && in_tdata[pip_pkg::VCOUNT_LSB + pip_pkg::VCOUNT_W - 1];
    end
  end

  assign ld_edge = '{ld_a: adv[2], ld_b: adv[3]};
  assign ld_mul  = '{ld_a: adv[4], ld_b: adv[5]};

  for (genvar i = 0; i < MAX_VERTICES; i++) begin : g_lane
    // Far end of edge i: next vertex, wrapping to vertex 0 after the last one in use
    if (i + 1 < 3) begin : g_mid
      assign xj[i]   = vx_r[i+1];
      assign yj[i]   = vy_r[i+1];
      assign used[i] = 1'b1;
    end else if (i + 1 < MAX_VERTICES) begin : g_third
      assign xj[i]   = quad_r ? vx_r[i+1] : vx_r[0];
      assign yj[i]   = quad_r ? vy_r[i+1] : vy_r[0];
      assign used[i] = 1'b1;
    end else begin : g_close
      assign xj[i]   = vx_r[0];
      assign yj[i]   = vy_r[0];
      assign used[i] = (i < 3) || quad_r;
    end

    pip_edge #(
      .COORD_WIDTH (COORD_WIDTH)
    ) u_edge (
      .clk       (clk),
      .ld        (ld_edge),
      .edge_used (used[i]),
      .px        (px_r),
      .py        (py_r),
      .xi        (vx_r[i]),
      .yi        (vy_r[i]),
      .xj        (xj[i]),
      .yj        (yj[i]),
      .dyp       (dyp[i]),
      .dxe       (dxe[i]),
      .dxp       (dxp[i]),
      .dye       (dye[i]),
      .hit_en    (en3[i])
    );

    // (py - ymin) * (xb - xa)
    pip_mul #(
      .AW (DW)
    ) u_mul_l (
      .clk  (clk),
      .ld   (ld_mul),
      .a    (dyp[i]),
      .b    (dxe[i]),
      .prod (lhs[i])
    );

    // (px - xa) * (ymax - ymin)
    pip_mul #(
      .AW (DW)
    ) u_mul_r (
      .clk  (clk),
      .ld   (ld_mul),
      .a    (dxp[i]),
      .b    (dye[i]),
      .prod (rhs[i])
    );
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_VERTICES; i++) begin
      if (adv[4]) begin
        en4_r[i] <= en3[i];
      end
      if (adv[5]) begin
        en5_r[i] <= en4_r[i];
      end
    end
  end

  always_comb begin
    count_nxt = '0;
    for (int i = 0; i < MAX_VERTICES; i++) begin
      count_nxt = count_nxt + CW'(en5_r[i] && (lhs[i] > rhs[i]));
    end
  end

  always_ff @(posedge clk) begin
    if (adv[NS]) begin
      count_r <= count_nxt;
    end
  end

  assign out_tdata = {{(pip_pkg::OUT_TDATA_W - pip_pkg::OUT_FIELDS_W){1'b0}}, count_r, count_r[0]};

endmodule

[sim/point_in_polygon_test_test.sv]
`timescale 1ns / 1ps

module point_in_polygon_test_test;

  localparam int U    = 32'sh0001_0000;
  localparam int QMAX = 32'sh7FFF_FFFF;
  localparam int QMIN = 32'sh8000_0000;
  localparam int RANDOM_QUERIES = 1300;
  localparam int LONG_HOLD = 80;

  // Highest field first, so the packed struct matches the in_tdata layout.
  typedef struct packed {
    logic [2:0]       vcount;
    logic [3:0][63:0] verts;   // per vertex: y in [63:32], x in [31:0]
    logic [31:0]      py;
    logic [31:0]      px;
  } query_t;

  typedef struct packed {
    logic [2:0] crossings;
    logic       in_poly;
  } verdict_t;

  typedef struct packed {
    query_t   q;
    logic     typed;
    verdict_t res;
  } directed_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [pip_pkg::IN_TDATA_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [pip_pkg::OUT_TDATA_W-1:0] out_tdata;

  verdict_t pending_verdicts [$];
  int bad_results = 0;
  int results_seen = 0;
  int queries_sent = 0;
  int inside_seen = 0;
  int crossing_hist [5] = '{default: 0};

  point_in_polygon_test i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic query_t make_query(int px, int py, int x0, int y0, int x1, int y1,
                                        int x2, int y2, int x3, int y3, int vc);
    query_t q;
    q.px = px;
    q.py = py;
    q.verts[0] = {y0, x0};
    q.verts[1] = {y1, x1};
    q.verts[2] = {y2, x2};
    q.verts[3] = {y3, x3};
    q.vcount = vc[2:0];
    return q;
  endfunction

  function automatic verdict_t verdict(int c);
    verdict_t v;
    v.crossings = c[2:0];
    v.in_poly = c[0];
    return v;
  endfunction

  // Crossing number with exact cross-multiplied compare instead of a division.
  function automatic verdict_t count_crossings(query_t q);
    logic signed [31:0] xs [4];
    logic signed [31:0] ys [4];
    logic signed [31:0] px, py, ylo, yhi, xlo, xhi;
    logic signed [71:0] rise, run_edge, run_pt, span;
    int corners, hits, j;
    px = q.px;
    py = q.py;
    for (int i = 0; i < 4; i++) begin
      xs[i] = q.verts[i][31:0];
      ys[i] = q.verts[i][63:32];
    end
    corners = (q.vcount >= 3'd4) ? 4 : 3;
    if (corners > pip_pkg::MAX_VERTICES_DEF) corners = pip_pkg::MAX_VERTICES_DEF;
    hits = 0;
    for (int i = 0; i < corners; i++) begin
      j = (i + 1 < corners) ? i + 1 : 0;
      if (ys[i] != ys[j]) begin
        if (ys[i] > ys[j]) begin
          ylo = ys[j]; yhi = ys[i]; xlo = xs[j]; xhi = xs[i];
        end else begin
          ylo = ys[i]; yhi = ys[j]; xlo = xs[i]; xhi = xs[j];
        end
        if (py > ylo && py <= yhi) begin
          rise = py;
          rise = rise - ylo;
          span = yhi;
          span = span - ylo;
          run_edge = xhi;
          run_edge = run_edge - xlo;
          run_pt = px;
          run_pt = run_pt - xlo;
          if (rise * run_edge > run_pt * span) hits++;
        end
      end
    end
    return verdict(hits);
  endfunction

  function automatic int pick_coord(int style);
    int c;
    case (style)
      0: begin
        // small grid: many shared y values and points on edges and vertices
        c = (int'($urandom_range(0, 16)) - 8) * U;
        if ($urandom_range(0, 3) == 0) c = c + int'($urandom_range(0, 2)) - 1;
      end
      1: c = int'($urandom_range(0, 32'h01FF_FFFF)) - 32'sh0100_0000;
      2: c = int'($urandom);
      default: begin
        case ($urandom_range(0, 6))
          0: c = QMIN;
          1: c = QMAX;
          2: c = 0;
          3: c = -1;
          4: c = 1;
          5: c = U;
          default: c = int'($urandom);
        endcase
      end
    endcase
    return c;
  endfunction

  function automatic query_t random_query();
    query_t q;
    int pick, style;
    pick = $urandom_range(0, 19);
    style = (pick < 10) ? 0 : (pick < 15) ? 1 : (pick < 18) ? 2 : 3;
    q.px = pick_coord(style);
    q.py = pick_coord(style);
    for (int i = 0; i < 4; i++) q.verts[i] = {pick_coord(style), pick_coord(style)};
    if ($urandom_range(0, 6) == 0) q.vcount = 3'($urandom_range(0, 7));
    else q.vcount = $urandom_range(0, 1) ? 3'd4 : 3'd3;
    return q;
  endfunction

  task automatic offer_query(query_t q, logic typed, verdict_t res);
    verdict_t want;
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata <= pip_pkg::IN_TDATA_W'(q);
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    want = typed ? res : count_crossings(q);
    pending_verdicts = {pending_verdicts, want};
    queries_sent++;
  endtask

  task automatic idle_input(int cycles);
    if (cycles > 0) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (cycles - 1) @(negedge clk);
    end
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    directed_row_t directed_rows [25];
    int burst, random_sent;
    bit paused;
    directed_rows = '{
      '{make_query(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 3), 1'b1, verdict(0)},
      '{make_query(QMIN, QMIN, QMIN, QMIN, QMIN, QMIN, QMIN, QMIN, QMIN, QMIN, 4),
        1'b1, verdict(0)},
      '{make_query(QMAX, QMAX, QMAX, QMAX, QMAX, QMAX, QMAX, QMAX, QMAX, QMAX, 7),
        1'b1, verdict(0)},
      '{make_query(U, U, 0, 0, 4*U, 0, 4*U, 4*U, 0, 4*U, 4), 1'b1, verdict(1)},
      '{make_query(-U, U, 0, 0, 4*U, 0, 4*U, 4*U, 0, 4*U, 4), 1'b1, verdict(2)},
      '{make_query(5*U, U, 0, 0, 4*U, 0, 4*U, 4*U, 0, 4*U, 4), 1'b1, verdict(0)},
      '{make_query(QMAX, U, 0, 0, 4*U, 0, 4*U, 4*U, 0, 4*U, 4), 1'b1, verdict(0)},
      '{make_query(0, U, U, U, U, U, U, U, U, U, 4), 1'b1, verdict(0)},
      // point level with the top and with the bottom of the vertical edges, then on the right edge
      '{make_query(U, 4*U, 0, 0, 4*U, 0, 4*U, 4*U, 0, 4*U, 4), 1'b0, verdict(0)},
      '{make_query(U, 0, 0, 0, 4*U, 0, 4*U, 4*U, 0, 4*U, 4), 1'b0, verdict(0)},
      '{make_query(4*U, U, 0, 0, 4*U, 0, 4*U, 4*U, 0, 4*U, 4), 1'b0, verdict(0)},
      // three vertices: vertex 3 holds junk that must not matter
      '{make_query(U, U, 0, 0, 4*U, 0, 0, 4*U, QMIN, QMAX, 3), 1'b0, verdict(0)},
      // out-of-range vertex counts
      '{make_query(U, 3*U, 0, 0, 4*U, 0, 4*U, 4*U, 0, 4*U, 0), 1'b0, verdict(0)},
      '{make_query(U, 3*U, 0, 0, 4*U, 0, 4*U, 4*U, 0, 4*U, 1), 1'b0, verdict(0)},
      '{make_query(U, 3*U, 0, 0, 4*U, 0, 4*U, 4*U, 0, 4*U, 2), 1'b0, verdict(0)},
      '{make_query(U, 3*U, 0, 0, 4*U, 0, 4*U, 4*U, 0, 4*U, 5), 1'b0, verdict(0)},
      '{make_query(U, 3*U, 0, 0, 4*U, 0, 4*U, 4*U, 0, 4*U, 6), 1'b0, verdict(0)},
      '{make_query(U, 3*U, 0, 0, 4*U, 0, 4*U, 4*U, 0, 4*U, 7), 1'b0, verdict(0)},
      // full-scale coordinates stress the product widths
      '{make_query(QMIN, 0, QMAX, QMIN, QMAX, QMAX, QMIN, QMAX, 0, 0, 3), 1'b0, verdict(0)},
      '{make_query(0, 0, QMIN, QMIN, QMAX, QMIN, QMAX, QMAX, QMIN, QMAX, 4),
        1'b0, verdict(0)},
      '{make_query(QMIN, QMAX, QMIN, QMIN, QMAX, QMIN, QMAX, QMAX, QMIN, QMAX, 4),
        1'b0, verdict(0)},
      '{make_query(QMAX, QMIN + 1, QMIN, QMIN, QMAX, QMIN, QMAX, QMAX, QMIN, QMAX, 4),
        1'b0, verdict(0)},
      // point exactly on a sloped edge, a bowtie, a collinear triangle
      '{make_query(2*U, 2*U, 0, 0, 4*U, 4*U, 4*U, 0, 0, 0, 3), 1'b0, verdict(0)},
      '{make_query(3*U, 2*U, 0, 0, 4*U, 4*U, 4*U, 0, 0, 4*U, 4), 1'b0, verdict(0)},
      '{make_query(-U, U, 0, 0, 0, 4*U, 0, 2*U, 0, 0, 3), 1'b0, verdict(0)}
    };

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[r])
      offer_query(directed_rows[r].q, directed_rows[r].typed, directed_rows[r].res);
    drain_results();

    random_sent = 0;
    paused = 1'b0;
    while (random_sent < RANDOM_QUERIES) begin
      burst = $urandom_range(1, 40);
      for (int k = 0; k < burst && random_sent < RANDOM_QUERIES; k++) begin
        offer_query(random_query(), 1'b0, verdict(0));
        random_sent++;
      end
      if (!paused && random_sent >= RANDOM_QUERIES / 2) begin
        paused = 1'b1;
        drain_results();
      end else if ($urandom_range(0, 3) != 0) begin
        idle_input($urandom_range(1, 8));
      end
    end
    drain_results();
    repeat (3 * pip_pkg::NUM_STAGES) @(posedge clk);

    $display("%0d polygon queries checked (25 directed), %0d reported inside",
             results_seen, inside_seen);
    $display("crossing counts 0..4 seen %0d/%0d/%0d/%0d/%0d times",
             crossing_hist[0], crossing_hist[1], crossing_hist[2],
             crossing_hist[3], crossing_hist[4]);
    if (bad_results == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Result side: random stall modes, plus one long hold so the pipe backs up.
  initial begin : receiver
    int cyc, mode, hold_left;
    bit held;
    cyc = 0;
    mode = 0;
    hold_left = 0;
    held = 1'b0;
    forever begin
      @(negedge clk);
      cyc++;
      if (cyc % 50 == 0) mode = $urandom_range(0, 3);
      if (!held && results_seen >= 400) begin
        held = 1'b1;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        case (mode)
          0: out_tready <= 1'b1;
          1: out_tready <= 1'($urandom_range(0, 1));
          2: out_tready <= ($urandom_range(0, 3) == 0);
          default: out_tready <= (cyc % 5 != 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    verdict_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[$bits(verdict_t)-1:0];
      results_seen++;
      if (pending_verdicts.size() == 0) begin
        $error("result with no query pending: out_tdata %h", out_tdata);
        bad_results++;
      end else begin
        want = pending_verdicts.pop_front();
        if (want.crossings <= 3'd4) crossing_hist[want.crossings]++;
        if (want.in_poly) inside_seen++;
        if (got.in_poly !== want.in_poly) begin
          $error("inside_res: expected %0d, got %0d", want.in_poly, got.in_poly);
          bad_results++;
        end
        if (got.crossings !== want.crossings) begin
          $error("crossing_count: expected %0d, got %0d", want.crossings, got.crossings);
          bad_results++;
        end
      end
    end
  end

  initial begin : watchdog
    #4_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

[point_in_polygon_test.f]
sv/pip_pkg.sv
sv/pip_edge.sv
sv/pip_mul.sv
sv/point_in_polygon_test.sv
sim/point_in_polygon_test_test.sv
